### rtl/blocking_bound_accumulator_defines.svh
// Assertion macros for the blocking bound accumulator.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef BLOCKING_BOUND_ACCUMULATOR_DEFINES_SVH
`define BLOCKING_BOUND_ACCUMULATOR_DEFINES_SVH

`ifndef ASSERT_OFF
// same-cycle implication, disabled during reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### rtl/bba_pkg.sv
// Shared types and constants for the blocking bound accumulator.
// No dependencies.
package bba_pkg;

    // configuration register indexes
    localparam logic [2:0] CFG_INTERVAL      = 3'd0;
    localparam logic [2:0] CFG_MAX_TOTAL     = 3'd1;
    localparam logic [2:0] CFG_MAX_PER_SRC   = 3'd2;
    localparam logic [2:0] CFG_PRIO_FLOOR    = 3'd3;
    localparam logic [2:0] CFG_CLUSTER_EN    = 3'd4;
    localparam logic [2:0] CFG_EXCL_CLUSTER  = 3'd5;

    // divider runs one quotient bit per step over a 33-bit window
    localparam int          DivSteps = 33;
    localparam logic [5:0]  DIV_LAST = 6'(DivSteps - 1);

    localparam logic [31:0] U32_MAX = 32'hFFFF_FFFF;
    localparam logic [63:0] U64_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

    // live configuration
    typedef struct packed {
        logic [31:0] interval;
        logic [31:0] max_total;
        logic [31:0] max_per_src;
        logic [31:0] prio_floor;
        logic        cluster_en;
        logic [7:0]  excl_cluster;
    } t_cfg;

    // classified item passed from front to back
    typedef struct packed {
        logic [32:0] window;
        logic [31:0] period;
        logic [15:0] reqs;
        logic [31:0] len;
        logic        eligible;
        logic        last;
    } t_item;

    // queue status
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // back-end status
    typedef struct packed {
        logic        dividing;
        logic [5:0]  div_cnt;
        logic [31:0] budget;
        logic        res_load;
    } t_back_stat;

endpackage

### rtl/bba_cfg.sv
// Configuration register file for the blocking bound accumulator.
// Depends on bba_pkg.
module bba_cfg
    import bba_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    output t_cfg        o_cfg,
    output logic        o_budget_reload,
    output logic [31:0] o_budget_value
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    // decode the write; out-of-range indexes are dropped
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_INTERVAL:     n_cfg.interval     = i_cfg_data;
                CFG_MAX_TOTAL:    n_cfg.max_total    = i_cfg_data;
                CFG_MAX_PER_SRC:  n_cfg.max_per_src  = i_cfg_data;
                CFG_PRIO_FLOOR:   n_cfg.prio_floor   = i_cfg_data;
                CFG_CLUSTER_EN:   n_cfg.cluster_en   = i_cfg_data[0];
                CFG_EXCL_CLUSTER: n_cfg.excl_cluster = i_cfg_data[7:0];
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.interval     <= '0;
            r_cfg.max_total    <= U32_MAX;
            r_cfg.max_per_src  <= U32_MAX;
            r_cfg.prio_floor   <= '0;
            r_cfg.cluster_en   <= 1'b0;
            r_cfg.excl_cluster <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg           = r_cfg;
    // budget follows a write of the total-request limit at once, with the new value
    assign o_budget_reload = i_cfg_we && (i_cfg_idx == CFG_MAX_TOTAL);
    assign o_budget_value  = i_cfg_data;

endmodule

### rtl/bba_front.sv
// Front end: accepts input transactions, classifies eligibility, forms the window.
// Depends on bba_pkg.
module bba_front
    import bba_pkg::*;
(
    input  t_cfg        i_cfg,
    input  logic        i_in_valid,
    input  logic [31:0] i_period,
    input  logic [31:0] i_response,
    input  logic [15:0] i_requests_per_job,
    input  logic [31:0] i_request_length,
    input  logic [31:0] i_priority_req,
    input  logic [7:0]  i_cluster,
    input  logic        i_is_excluded_task,
    input  logic        i_last,
    input  t_q_stat     i_q_stat,
    output logic        o_in_stall,
    output logic        o_push,
    output t_item       o_item
);

    logic w_cluster_ok;

    // cluster exclusion only when enabled
    assign w_cluster_ok = !i_cfg.cluster_en || (i_cluster != i_cfg.excl_cluster);

    always_comb begin
        o_item.window   = {1'b0, i_cfg.interval} + {1'b0, i_response};
        o_item.period   = i_period;
        o_item.reqs     = i_requests_per_job;
        o_item.len      = i_request_length;
        o_item.eligible = !i_is_excluded_task && (i_priority_req >= i_cfg.prio_floor)
                          && w_cluster_ok;
        o_item.last     = i_last;
    end

    assign o_in_stall = i_q_stat.full;
    assign o_push     = i_in_valid && !i_q_stat.full;

endmodule

### rtl/bba_queue.sv
// Two-entry queue between front and back ends.
// Depends on bba_pkg.
module bba_queue
    import bba_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_item   i_item,
    input  logic    i_pop,
    output t_item   o_item,
    output t_q_stat o_stat
);

    t_item      r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_count;
    logic       w_push;
    logic       w_pop;

    assign w_push = i_push && (r_count != 2'd2);
    assign w_pop  = i_pop && (r_count != 2'd0);

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= '0;
        end else begin
            if (w_push) r_wr <= ~r_wr;
            if (w_pop)  r_rd <= ~r_rd;
            unique case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wr] <= i_item;
    end

    assign o_item       = r_mem[r_rd];
    assign o_stat.full  = (r_count == 2'd2);
    assign o_stat.empty = (r_count == 2'd0);

endmodule

### rtl/bba_back.sv
// Back end: serial ceiling divide, request clamp, length product, saturating totals.
// Depends on bba_pkg.
module bba_back
    import bba_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_budget_reload,
    input  logic [31:0] i_budget_value,
    input  t_q_stat     i_q_stat,
    input  t_item       i_item,
    output logic        o_pop,
    input  logic        i_out_stall,
    output logic        o_out_valid,
    output logic [63:0] o_blocking_length,
    output logic [31:0] o_request_count,
    output t_back_stat  o_stat
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DIV  = 5'b00010,
        S_MUL  = 5'b00100,
        S_PROD = 5'b01000,
        S_ACC  = 5'b10000
    } t_state;

    t_state      r_state, n_state;
    t_item       r_item;
    logic [32:0] r_quo;
    logic [32:0] r_rem;
    logic [5:0]  r_cnt;
    logic [31:0] r_num;
    logic [63:0] r_add;
    logic [31:0] r_budget;
    logic [63:0] r_len_sum;
    logic [31:0] r_cnt_sum;
    logic        r_out_valid;
    logic [63:0] r_out_len;
    logic [31:0] r_out_cnt;

    logic        w_start;
    logic        w_out_free;
    logic        w_acc_go;
    logic        w_res_load;
    logic [32:0] w_rem_sh;
    logic        w_ge;
    logic [32:0] w_jobs;
    logic [48:0] w_prod;
    logic [31:0] w_num_sat;
    logic [31:0] w_num_cap;
    logic [31:0] w_num;
    logic [64:0] w_len_next;
    logic [32:0] w_cnt_next;
    logic [63:0] w_len_sat;
    logic [31:0] w_cnt_sat;

    // item needs the full computation
    assign w_start    = i_item.eligible && (r_budget != '0);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_acc_go   = !r_item.last || w_out_free;
    assign w_res_load = (r_state == S_ACC) && r_item.last && w_out_free;
    assign o_pop      = (r_state == S_IDLE) && !i_q_stat.empty;

    // restoring divide step
    assign w_rem_sh = {r_rem[31:0], r_quo[32]};
    assign w_ge     = w_rem_sh >= {1'b0, r_item.period};

    // ceiling, product with reqs, clamp to cap and budget
    assign w_jobs    = r_quo + {32'd0, (r_rem != '0)};
    assign w_prod    = w_jobs * {33'd0, r_item.reqs};
    assign w_num_sat = (w_prod[48:32] != '0) ? U32_MAX : w_prod[31:0];
    assign w_num_cap = (w_num_sat < i_cfg.max_per_src) ? w_num_sat : i_cfg.max_per_src;
    assign w_num     = (w_num_cap < r_budget) ? w_num_cap : r_budget;

    // saturating totals
    assign w_len_next = {1'b0, r_len_sum} + {1'b0, r_add};
    assign w_cnt_next = {1'b0, r_cnt_sum} + {1'b0, r_num};
    assign w_len_sat  = w_len_next[64] ? U64_MAX : w_len_next[63:0];
    assign w_cnt_sat  = w_cnt_next[32] ? U32_MAX : w_cnt_next[31:0];

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (!i_q_stat.empty) begin
                    if (!w_start)                  n_state = S_PROD;
                    else if (i_item.period == '0)  n_state = S_MUL;
                    else                           n_state = S_DIV;
                end
            end
            S_DIV:  if (r_cnt == DIV_LAST) n_state = S_MUL;
            S_MUL:  n_state = S_PROD;
            S_PROD: n_state = S_ACC;
            S_ACC:  if (w_acc_go) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_item <= i_item;
                r_rem  <= '0;
                r_cnt  <= '0;
                r_num  <= '0;
                // zero period takes the largest job count
                r_quo  <= (i_item.period == '0) ? '1 : i_item.window;
            end
            S_DIV: begin
                r_rem <= w_ge ? (w_rem_sh - {1'b0, r_item.period}) : w_rem_sh;
                r_quo <= {r_quo[31:0], w_ge};
                r_cnt <= r_cnt + 6'd1;
            end
            S_MUL:  r_num <= w_num;
            S_PROD: r_add <= {32'd0, r_num} * {32'd0, r_item.len};
            S_ACC:  r_add <= r_add;
            default: r_add <= r_add;
        endcase
    end

    // totals, budget and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_budget    <= U32_MAX;
            r_len_sum   <= '0;
            r_cnt_sum   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // result handshake
            if (w_res_load)                       r_out_valid <= 1'b1;
            else if (r_out_valid && !i_out_stall) r_out_valid <= 1'b0;
            if (i_budget_reload) begin
                r_budget <= i_budget_value;
            end else if ((r_state == S_ACC) && w_acc_go) begin
                if (r_item.last) begin
                    r_len_sum   <= '0;
                    r_cnt_sum   <= '0;
                    r_budget    <= i_cfg.max_total;
                end else begin
                    r_len_sum   <= w_len_sat;
                    r_cnt_sum   <= w_cnt_sat;
                    r_budget    <= r_budget - r_num;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_load) begin
            r_out_len <= w_len_sat;
            r_out_cnt <= w_cnt_sat;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_blocking_length = r_out_len;
    assign o_request_count   = r_out_cnt;

    assign o_stat.dividing = (r_state == S_DIV);
    assign o_stat.div_cnt  = r_cnt;
    assign o_stat.budget   = r_budget;
    assign o_stat.res_load = w_res_load;

endmodule

### rtl/blocking_bound_accumulator.sv
// Remote blocking bound for a FIFO-ordered lock. Each input transaction describes one
// request source; the block counts min(ceil((interval+response)/period)*requests,
// per-source cap, remaining budget) requests and sums their lengths, and the
// transaction marked last returns the totals and starts a new contention set.
// An eligible source passes through load, the serial divider (one quotient bit per cycle
// over 33 bits), product, length multiply and accumulate in the back end; a zero
// period skips the divider; a skipped source, or one arriving with the budget spent,
// also skips the product. A last source waits in accumulate while the previous
// result is still held by a stalled receiver.
// A two-entry queue lets the input accept while the back end works, and the
// result register holds a finished result while the next source is processed.
// Depends on bba_pkg and the submodules bba_cfg, bba_front, bba_queue, bba_back.
`include "blocking_bound_accumulator_defines.svh"

module blocking_bound_accumulator
    import bba_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_period,
    input  logic [31:0] i_response,
    input  logic [15:0] i_requests_per_job,
    input  logic [31:0] i_request_length,
    input  logic [31:0] i_priority_req,
    input  logic [7:0]  i_cluster,
    input  logic        i_is_excluded_task,
    input  logic        i_last,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [63:0] o_blocking_length,
    output logic [31:0] o_request_count
);

    t_cfg        w_cfg;
    logic        w_budget_reload;
    logic [31:0] w_budget_value;
    logic        w_push;
    logic        w_pop;
    t_item       w_front_item;
    t_item       w_q_item;
    t_q_stat     w_q_stat;
    t_back_stat  w_back_stat;

    bba_cfg u_cfg (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .o_cfg           (w_cfg),
        .o_budget_reload (w_budget_reload),
        .o_budget_value  (w_budget_value)
    );

    bba_front u_front (
        .i_cfg              (w_cfg),
        .i_in_valid         (i_in_valid),
        .i_period           (i_period),
        .i_response         (i_response),
        .i_requests_per_job (i_requests_per_job),
        .i_request_length   (i_request_length),
        .i_priority_req     (i_priority_req),
        .i_cluster          (i_cluster),
        .i_is_excluded_task (i_is_excluded_task),
        .i_last             (i_last),
        .i_q_stat           (w_q_stat),
        .o_in_stall         (o_in_stall),
        .o_push             (w_push),
        .o_item             (w_front_item)
    );

    bba_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .i_pop   (w_pop),
        .o_item  (w_q_item),
        .o_stat  (w_q_stat)
    );

    bba_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (w_cfg),
        .i_budget_reload   (w_budget_reload),
        .i_budget_value    (w_budget_value),
        .i_q_stat          (w_q_stat),
        .i_item            (w_q_item),
        .o_pop             (w_pop),
        .i_out_stall       (i_out_stall),
        .o_out_valid       (o_out_valid),
        .o_blocking_length (o_blocking_length),
        .o_request_count   (o_request_count),
        .o_stat            (w_back_stat)
    );

    // accepted transaction leaves the queue non-empty
    `ASSERT_NEXT(a_push_lands, i_clk, i_rst_n, i_in_valid && !o_in_stall, !w_q_stat.empty)
    // divider step counter stays within the quotient width
    `ASSERT_IMPLY(a_div_range, i_clk, i_rst_n, w_back_stat.dividing, w_back_stat.div_cnt <= DIV_LAST)
    // budget only shrinks between reloads
    `ASSERT_NEXT(a_budget_mono, i_clk, i_rst_n, !i_cfg_we && !w_back_stat.res_load, w_back_stat.budget <= $past(w_back_stat.budget))

endmodule
